// File: rtl/core/pdtc_pkg.sv
`timescale 1ns / 1ps

package pdtc_pkg;

   // Defaults for the top-level parameters
   localparam int TIME_WIDTH_DEF     = 48;
   localparam int CATCH_UP_LIMIT_DEF = 8;

   // Counter clock and time base
   localparam int unsigned CLOCK_HZ     = 33868800;
   localparam int unsigned US_PER_S     = 1000000;
   localparam int unsigned FULL_TARGET  = 32'h10000;
   localparam int unsigned SLOW_DIVIDER = 8;

   // period = target * divider * 625 / 21168 (ratio reduced by the common factor 1600)
   localparam int unsigned PERIOD_GCD = 1600;
   localparam int unsigned PERIOD_NUM = US_PER_S / PERIOD_GCD;
   localparam int unsigned PERIOD_DEN = CLOCK_HZ / PERIOD_GCD;

   // Field and datapath widths
   localparam int TARGET_W   = 16;
   localparam int TGT_EXT_W  = TARGET_W + 1;
   localparam int PERIOD_W   = 14;
   localparam int CALLS_W    = 5;
   localparam int SLOW_SHIFT = $clog2(SLOW_DIVIDER);
   localparam int PROD_W     = $clog2(FULL_TARGET * PERIOD_NUM + 1);
   localparam int DIV_W      = $clog2(FULL_TARGET * SLOW_DIVIDER * PERIOD_NUM + 1);

   // Reciprocal of the divisor: quotient = (dividend * RECIP_MUL) >> RECIP_SHIFT,
   // exact for every dividend below 2**DIV_W
   localparam int RECIP_SHIFT = DIV_W + $clog2(PERIOD_DEN);
   localparam int RECIP_W     = DIV_W + 1;
   localparam logic [RECIP_W-1:0] RECIP_MUL =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(PERIOD_DEN) - 64'd1) / 64'(PERIOD_DEN));

   // Register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_RELOAD_TARGET     = 2'd0,
      REG_CLOCK_SELECT      = 2'd1,
      REG_TIMER_RUNNING     = 2'd2,
      REG_HANDLER_INSTALLED = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_ENTER  = 2'd1,
      OP_EXIT   = 2'd2,
      OP_VBLANK = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PLOAD,
      ST_DIV,
      ST_ARM,
      ST_LOOP,
      ST_RESYNC,
      ST_DONE
   } state_type;

   // Configuration handed from the register block to the sequencer
   typedef struct packed {
      logic [TARGET_W-1:0] reload_target;
      logic                clock_select;
      logic                timer_running;
      logic                handler_installed;
      logic                period_load;
   } cfg_type;

   // Dividend of the period computation: target * divider * PERIOD_NUM
   function automatic logic [DIV_W-1:0] period_dividend(input logic [TARGET_W-1:0] target,
                                                        input logic clk_sel);
      logic [TGT_EXT_W-1:0] t_ext;
      logic [PROD_W-1:0]    prod;
      t_ext = (target == '0) ? TGT_EXT_W'(FULL_TARGET) : {1'b0, target};
      prod  = PROD_W'(t_ext * PERIOD_NUM);
      return clk_sel ? DIV_W'(prod) : (DIV_W'(prod) << SLOW_SHIFT);
   endfunction

endpackage

// File: rtl/core/pdtc_if.sv
`timescale 1ns / 1ps

// Input channel
interface pdtc_req_if #(
   parameter int TIME_WIDTH = pdtc_pkg::TIME_WIDTH_DEF
);
   logic                   valid;
   logic                   ready;
   pdtc_pkg::opcode_type   opcode;
   logic [TIME_WIDTH-1:0]  now_us;

   modport source (output valid, opcode, now_us, input ready);
   modport sink   (input valid, opcode, now_us, output ready);
endinterface

// Result channel
interface pdtc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pdtc_pkg::CALLS_W-1:0]  handler_calls;
   logic                          vblank_delivered;
   logic                          fresh_entry;

   modport source (output valid, handler_calls, vblank_delivered, fresh_entry, input ready);
   modport sink   (input valid, handler_calls, vblank_delivered, fresh_entry, output ready);
endinterface

// File: rtl/core/pdtc_alu.sv
`timescale 1ns / 1ps

// Shared unit: saturating add and unsigned compare
module pdtc_alu #(
   parameter int TIME_WIDTH = pdtc_pkg::TIME_WIDTH_DEF
) (
   input  logic [TIME_WIDTH-1:0] add_a,
   input  logic [TIME_WIDTH-1:0] add_b,
   input  logic [TIME_WIDTH-1:0] cmp_a,
   input  logic [TIME_WIDTH-1:0] cmp_b,
   output logic [TIME_WIDTH-1:0] sum_sat,
   output logic                  ge
);
   import pdtc_pkg::*;

   logic [TIME_WIDTH:0] sum_full;
   logic [TIME_WIDTH:0] diff_full;

   // add, clamp to all ones on carry out
   assign sum_full = {1'b0, add_a} + {1'b0, add_b};
   assign sum_sat  = sum_full[TIME_WIDTH] ? '1 : sum_full[TIME_WIDTH-1:0];

   // subtract, no borrow means a >= b
   assign diff_full = {1'b0, cmp_a} - {1'b0, cmp_b};
   assign ge        = ~diff_full[TIME_WIDTH];

endmodule

// File: rtl/core/pdtc_csr.sv
`timescale 1ns / 1ps

// Configuration registers behind the APB-style port
module pdtc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pdtc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pdtc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pdtc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output pdtc_pkg::cfg_type                   cfg
);
   import pdtc_pkg::*;

   logic [TARGET_W-1:0] reload_ff, reload_in;
   logic                clk_sel_ff, clk_sel_in;
   logic                running_ff, running_in;
   logic                installed_ff, installed_in;
   logic                wr_stb;
   reg_index_type       reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_stb     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // register write decode
   always_comb begin
      reload_in    = reload_ff;
      clk_sel_in   = clk_sel_ff;
      running_in   = running_ff;
      installed_in = installed_ff;
      if (wr_stb) begin
         case (reg_idx)
            REG_RELOAD_TARGET:     reload_in    = csr_pwdata[TARGET_W-1:0];
            REG_CLOCK_SELECT:      clk_sel_in   = csr_pwdata[0];
            REG_TIMER_RUNNING:     running_in   = csr_pwdata[0];
            REG_HANDLER_INSTALLED: installed_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff    <= '0;
         clk_sel_ff   <= 1'b0;
         running_ff   <= 1'b0;
         installed_ff <= 1'b0;
      end else begin
         reload_ff    <= reload_in;
         clk_sel_ff   <= clk_sel_in;
         running_ff   <= running_in;
         installed_ff <= installed_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_RELOAD_TARGET:     csr_prdata = CSR_DATA_W'(reload_ff);
         REG_CLOCK_SELECT:      csr_prdata = CSR_DATA_W'(clk_sel_ff);
         REG_TIMER_RUNNING:     csr_prdata = CSR_DATA_W'(running_ff);
         REG_HANDLER_INSTALLED: csr_prdata = CSR_DATA_W'(installed_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // a write to target or clock select restarts the period computation
   assign cfg.reload_target     = reload_ff;
   assign cfg.clock_select      = clk_sel_ff;
   assign cfg.timer_running     = running_ff;
   assign cfg.handler_installed = installed_ff;
   assign cfg.period_load       = wr_stb &
                                  ((reg_idx == REG_RELOAD_TARGET) ||
                                   (reg_idx == REG_CLOCK_SELECT));

endmodule

// File: rtl/core/pdtc_seq.sv
`timescale 1ns / 1ps

// Sequencer: event handling, period computation and deadline catch-up on the shared unit
module pdtc_seq #(
   parameter int TIME_WIDTH     = pdtc_pkg::TIME_WIDTH_DEF,
   parameter int CATCH_UP_LIMIT = pdtc_pkg::CATCH_UP_LIMIT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pdtc_pkg::cfg_type     cfg,
   pdtc_req_if.sink              req_chan,
   pdtc_rsp_if.source            rsp_chan,
   output logic [TIME_WIDTH-1:0] alu_add_a,
   output logic [TIME_WIDTH-1:0] alu_add_b,
   output logic [TIME_WIDTH-1:0] alu_cmp_a,
   output logic [TIME_WIDTH-1:0] alu_cmp_b,
   input  logic [TIME_WIDTH-1:0] alu_sum,
   input  logic                  alu_ge
);
   import pdtc_pkg::*;

   localparam int CNT_W    = $clog2(CATCH_UP_LIMIT + 1);
   localparam int RPROD_W  = DIV_W + RECIP_W;
   localparam logic [CNT_W-1:0] CALL_MAX = CNT_W'(CATCH_UP_LIMIT);

   state_type              state_ff, state_in;
   logic [PERIOD_W-1:0]    period_ff, period_in;
   logic [TIME_WIDTH-1:0]  deadline_ff, deadline_in;
   logic                   armed_ff, armed_in;
   logic                   in_crit_ff, in_crit_in;
   logic                   tick_pend_ff, tick_pend_in;
   logic                   vb_pend_ff, vb_pend_in;
   logic [TIME_WIDTH-1:0]  last_time_ff, last_time_in;
   logic [TIME_WIDTH-1:0]  work_time_ff, work_time_in;
   logic [CNT_W-1:0]       calls_ff, calls_in;
   logic                   vb_res_ff, vb_res_in;
   logic                   en_res_ff, en_res_in;
   logic [DIV_W-1:0]       dividend_ff, dividend_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CALLS_W-1:0]     rsp_calls_ff, rsp_calls_in;
   logic                   rsp_vb_ff, rsp_vb_in;
   logic                   rsp_en_ff, rsp_en_in;

   logic                   req_xfer;
   logic                   serviceable;
   logic                   out_free;
   logic                   more_calls;
   logic [RPROD_W-1:0]     recip_prod;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid & req_chan.ready;
   assign serviceable    = cfg.timer_running & cfg.handler_installed & (period_ff != '0);
   assign out_free       = ~rsp_valid_ff | rsp_chan.ready;
   assign more_calls     = alu_ge & (calls_ff < CALL_MAX);

   // period = dividend / PERIOD_DEN by reciprocal multiplication
   assign recip_prod = RPROD_W'(dividend_ff) * RPROD_W'(RECIP_MUL);

   // shared unit operand select
   assign alu_cmp_a = work_time_ff;
   assign alu_cmp_b = deadline_ff;
   assign alu_add_a = ((state_ff == ST_ARM) || (state_ff == ST_RESYNC)) ?
                      work_time_ff : deadline_ff;
   assign alu_add_b = TIME_WIDTH'(period_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_DONE;
               case (req_chan.opcode)
                  OP_TICK: begin
                     if (!in_crit_ff && serviceable)
                        state_in = armed_ff ? ST_LOOP : ST_ARM;
                  end
                  OP_EXIT: begin
                     if (tick_pend_ff && serviceable)
                        state_in = armed_ff ? ST_LOOP : ST_ARM;
                  end
                  default: ;
               endcase
            end
         end
         ST_PLOAD:  state_in = ST_DIV;
         ST_DIV:    state_in = ST_IDLE;
         ST_ARM:    state_in = ST_LOOP;
         ST_LOOP: begin
            if (!more_calls)
               state_in = alu_ge ? ST_RESYNC : ST_DONE;
         end
         ST_RESYNC: state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
      if (cfg.period_load)
         state_in = ST_PLOAD;
   end

   // datapath updates per state
   always_comb begin
      period_in    = period_ff;
      deadline_in  = deadline_ff;
      armed_in     = armed_ff;
      in_crit_in   = in_crit_ff;
      tick_pend_in = tick_pend_ff;
      vb_pend_in   = vb_pend_ff;
      last_time_in = last_time_ff;
      work_time_in = work_time_ff;
      calls_in     = calls_ff;
      vb_res_in    = vb_res_ff;
      en_res_in    = en_res_ff;
      dividend_in  = dividend_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_calls_in = rsp_calls_ff;
      rsp_vb_in    = rsp_vb_ff;
      rsp_en_in    = rsp_en_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               calls_in  = '0;
               vb_res_in = 1'b0;
               en_res_in = 1'b0;
               case (req_chan.opcode)
                  OP_TICK: begin
                     last_time_in = req_chan.now_us;
                     work_time_in = req_chan.now_us;
                     if (in_crit_ff)
                        tick_pend_in = 1'b1;
                  end
                  OP_ENTER: begin
                     en_res_in  = ~in_crit_ff;
                     in_crit_in = 1'b1;
                  end
                  OP_EXIT: begin
                     in_crit_in   = 1'b0;
                     vb_res_in    = vb_pend_ff;
                     vb_pend_in   = 1'b0;
                     tick_pend_in = 1'b0;
                     work_time_in = last_time_ff;
                  end
                  OP_VBLANK: begin
                     if (in_crit_ff)
                        vb_pend_in = 1'b1;
                     else
                        vb_res_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_PLOAD: dividend_in = period_dividend(cfg.reload_target, cfg.clock_select);
         // quotient sits above the reciprocal shift
         ST_DIV:   period_in = recip_prod[RECIP_SHIFT +: PERIOD_W];
         ST_ARM: begin
            deadline_in = alu_sum;
            armed_in    = 1'b1;
         end
         // one passed deadline per cycle
         ST_LOOP: begin
            if (more_calls) begin
               deadline_in = alu_sum;
               calls_in    = calls_ff + 1'b1;
            end
         end
         // still behind after the limit: next deadline one period after the sample
         ST_RESYNC: deadline_in = alu_sum;
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_calls_in = CALLS_W'(calls_ff);
               rsp_vb_in    = vb_res_ff;
               rsp_en_in    = en_res_ff;
            end
         end
         default: ;
      endcase
      // new period disarms the deadline
      if (cfg.period_load) begin
         armed_in    = 1'b0;
         deadline_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= '0;
         deadline_ff  <= '0;
         armed_ff     <= 1'b0;
         in_crit_ff   <= 1'b0;
         tick_pend_ff <= 1'b0;
         vb_pend_ff   <= 1'b0;
         last_time_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         deadline_ff  <= deadline_in;
         armed_ff     <= armed_in;
         in_crit_ff   <= in_crit_in;
         tick_pend_ff <= tick_pend_in;
         vb_pend_ff   <= vb_pend_in;
         last_time_ff <= last_time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // work and result payload, no reset
   always_ff @(posedge clock) begin
      work_time_ff <= work_time_in;
      calls_ff     <= calls_in;
      vb_res_ff    <= vb_res_in;
      en_res_ff    <= en_res_in;
      dividend_ff  <= dividend_in;
      rsp_calls_ff <= rsp_calls_in;
      rsp_vb_ff    <= rsp_vb_in;
      rsp_en_ff    <= rsp_en_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.handler_calls    = rsp_calls_ff;
   assign rsp_chan.vblank_delivered = rsp_vb_ff;
   assign rsp_chan.fresh_entry      = rsp_en_ff;

endmodule

// File: rtl/core/periodic_deadline_timer_catch_up.sv
`timescale 1ns / 1ps
// Critical-section, vblank and deferred ticks go straight from the transfer to the result;
//   a serviced tick passes ARM (if unarmed), LOOP for each call and a final compare, RESYNC
//   (if behind at the limit), then the result; one deadline step per cycle on the shared adder.
// Throughput: one item at a time; input ready returns when the result is registered.
// Writing reload_target or clock_select runs the period computation (PLOAD, DIV), not ready.
// Reset: synchronous, active high; clears registers, timer state and the result valid.

module periodic_deadline_timer_catch_up #(
   parameter int TIME_WIDTH     = pdtc_pkg::TIME_WIDTH_DEF,
   parameter int CATCH_UP_LIMIT = pdtc_pkg::CATCH_UP_LIMIT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   pdtc_req_if.sink                         req_chan,
   pdtc_rsp_if.source                       rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pdtc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pdtc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pdtc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import pdtc_pkg::*;

   cfg_type                cfg;
   logic [TIME_WIDTH-1:0]  alu_add_a;
   logic [TIME_WIDTH-1:0]  alu_add_b;
   logic [TIME_WIDTH-1:0]  alu_cmp_a;
   logic [TIME_WIDTH-1:0]  alu_cmp_b;
   logic [TIME_WIDTH-1:0]  alu_sum;
   logic                   alu_ge;

   pdtc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pdtc_alu #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_alu (
      .add_a   (alu_add_a),
      .add_b   (alu_add_b),
      .cmp_a   (alu_cmp_a),
      .cmp_b   (alu_cmp_b),
      .sum_sat (alu_sum),
      .ge      (alu_ge)
   );

   pdtc_seq #(
      .TIME_WIDTH     (TIME_WIDTH),
      .CATCH_UP_LIMIT (CATCH_UP_LIMIT)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .alu_add_a (alu_add_a),
      .alu_add_b (alu_add_b),
      .alu_cmp_a (alu_cmp_a),
      .alu_cmp_b (alu_cmp_b),
      .alu_sum   (alu_sum),
      .alu_ge    (alu_ge)
   );

   // an item never fires the handler more than the catch-up limit
   a_calls_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.handler_calls <= CATCH_UP_LIMIT))
      else $error("handler_calls above catch-up limit");

   // enter-critical results carry nothing else
   a_enter_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.fresh_entry) |->
      ((rsp_chan.handler_calls == '0) && !rsp_chan.vblank_delivered))
      else $error("fresh_entry together with calls or vblank");

   // the block is busy in the cycle after an input transfer
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("input ready right after a transfer");

endmodule

// File: test/timer_result_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register ports of the deadline timer,
// keeps its own copy of the timer state and checks every result transfer.
module timer_result_checker (
   input  logic                             clock,
   input  logic                             reset,
   pdtc_req_if                              req_mon,
   pdtc_rsp_if                              rsp_mon,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pdtc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pdtc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input  logic                             csr_pready,
   output int                               error_count,
   output int                               open_results
);
   import pdtc_pkg::*;

   localparam int TW       = TIME_WIDTH_DEF;
   localparam int CATCH_UP = CATCH_UP_LIMIT_DEF;

   typedef struct packed {
      logic [CALLS_W-1:0] handler_calls;
      logic               vblank_delivered;
      logic               fresh_entry;
   } timer_result_type;

   // Register shadows
   logic [TARGET_W-1:0] cfg_target;
   logic                cfg_fast_clock;
   logic                cfg_running;
   logic                cfg_handler;

   // Timer and critical-section shadows
   logic [PERIOD_W-1:0] period_us;
   logic [TW-1:0]       deadline_us;
   logic                deadline_live;
   logic                crit_active;
   logic                tick_held;
   logic                vblank_held;
   logic [TW-1:0]       held_time;

   timer_result_type expected_results[$];
   timer_result_type want;
   int               fails = 0;

   // Deadline step that sticks at the top of the time range
   function automatic logic [TW-1:0] add_saturate(input logic [TW-1:0] base,
                                                  input logic [PERIOD_W-1:0] step);
      logic [TW:0] sum;
      sum = {1'b0, base} + (TW+1)'(step);
      return sum[TW] ? '1 : sum[TW-1:0];
   endfunction

   // New period from target and divider; disarms the deadline
   function automatic void reload_period();
      logic [63:0] eff_target;
      logic [63:0] scaled;
      eff_target = (cfg_target == '0) ? 64'(FULL_TARGET) : 64'(cfg_target);
      scaled = eff_target * (cfg_fast_clock ? 64'd1 : 64'(SLOW_DIVIDER)) * 64'(US_PER_S)
               / 64'(CLOCK_HZ);
      period_us     = scaled[PERIOD_W-1:0];
      deadline_live = 1'b0;
      deadline_us   = '0;
   endfunction

   // Handler calls for one time sample, bounded catch-up then resync
   function automatic logic [CALLS_W-1:0] fire_deadlines(input logic [TW-1:0] now);
      logic [CALLS_W-1:0] calls;
      calls = '0;
      if (!cfg_running || !cfg_handler || period_us == '0) begin
         return '0;
      end
      if (!deadline_live) begin
         deadline_us   = add_saturate(now, period_us);
         deadline_live = 1'b1;
      end
      while (now >= deadline_us && calls < CATCH_UP) begin
         deadline_us = add_saturate(deadline_us, period_us);
         calls++;
      end
      if (now >= deadline_us) begin
         deadline_us = add_saturate(now, period_us);
      end
      return calls;
   endfunction

   function automatic timer_result_type predict_result(input opcode_type op,
                                                       input logic [TW-1:0] now);
      timer_result_type res;
      res = '0;
      case (op)
         OP_TICK: begin
            held_time = now;
            if (crit_active) begin
               tick_held = 1'b1;
            end else begin
               res.handler_calls = fire_deadlines(now);
            end
         end
         OP_ENTER: begin
            res.fresh_entry = !crit_active;
            crit_active     = 1'b1;
         end
         OP_EXIT: begin
            crit_active = 1'b0;
            // deferred tick replays with the last sample, then the vblank
            if (tick_held) begin
               tick_held         = 1'b0;
               res.handler_calls = fire_deadlines(held_time);
            end
            if (vblank_held) begin
               vblank_held          = 1'b0;
               res.vblank_delivered = 1'b1;
            end
         end
         default: begin
            if (crit_active) begin
               vblank_held = 1'b1;
            end else begin
               res.vblank_delivered = 1'b1;
            end
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_target     = '0;
         cfg_fast_clock = 1'b0;
         cfg_running    = 1'b0;
         cfg_handler    = 1'b0;
         period_us      = '0;
         deadline_us    = '0;
         deadline_live  = 1'b0;
         crit_active    = 1'b0;
         tick_held      = 1'b0;
         vblank_held    = 1'b0;
         held_time      = '0;
         expected_results.delete();
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[3:2]))
               REG_RELOAD_TARGET: begin
                  cfg_target = csr_pwdata[TARGET_W-1:0];
                  reload_period();
               end
               REG_CLOCK_SELECT: begin
                  cfg_fast_clock = csr_pwdata[0];
                  reload_period();
               end
               REG_TIMER_RUNNING:     cfg_running = csr_pwdata[0];
               REG_HANDLER_INSTALLED: cfg_handler = csr_pwdata[0];
               default: ;
            endcase
         end

         // result transfer against the oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $error("result with no item outstanding: handler_calls %0d vblank %0b en %0b",
                      rsp_mon.handler_calls, rsp_mon.vblank_delivered, rsp_mon.fresh_entry);
               fails++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_mon.handler_calls !== want.handler_calls) begin
                  $error("handler_calls: expected %0d, actual %0d",
                         want.handler_calls, rsp_mon.handler_calls);
                  fails++;
               end
               if (rsp_mon.vblank_delivered !== want.vblank_delivered) begin
                  $error("vblank_delivered: expected %0b, actual %0b",
                         want.vblank_delivered, rsp_mon.vblank_delivered);
                  fails++;
               end
               if (rsp_mon.fresh_entry !== want.fresh_entry) begin
                  $error("fresh_entry: expected %0b, actual %0b",
                         want.fresh_entry, rsp_mon.fresh_entry);
                  fails++;
               end
            end
         end

         // request transfer
         if (req_mon.valid && req_mon.ready) begin
            expected_results.push_back(predict_result(req_mon.opcode, req_mon.now_us));
         end
      end
      open_results <= expected_results.size();
      error_count  <= fails;
   end

endmodule

// File: test/periodic_deadline_timer_catch_up_test.sv
`timescale 1ns / 1ps

module periodic_deadline_timer_catch_up_test;
   import pdtc_pkg::*;

   localparam int            TW                 = TIME_WIDTH_DEF;
   localparam logic [TW-1:0] TIME_MAX           = '1;
   localparam int            PERIOD_LOAD_CYCLES = 20;
   localparam int            ITEMS_PER_PHASE    = 85;
   localparam int            RANDOM_SETUPS      = 6;
   // period for target zero with the slow divider
   localparam int unsigned   FULL_SLOW_PERIOD   = 15479;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    error_count;
   int                    open_results;

   // Stimulus shaping
   logic          burst = 1'b0;
   int unsigned   step_us = 1;
   logic [TW-1:0] sim_time_us = '0;

   pdtc_req_if req_chan ();
   pdtc_rsp_if rsp_chan ();

   periodic_deadline_timer_catch_up i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   timer_result_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_pready   (csr_pready),
      .error_count  (error_count),
      .open_results (open_results)
   );

   always #5 clock = ~clock;

   // Idle cycles per transfer; burst stretches run with none
   function automatic int idle_cycles();
      if ($urandom_range(0, 24) == 0) begin
         burst = ~burst;
      end
      return burst ? 0 : $urandom_range(0, 3);
   endfunction

   function automatic logic [TW-1:0] random_time();
      return TW'({$urandom, $urandom});
   endfunction

   // Next time sample: mostly forward near the period, with catch-up runs,
   // repeats, regressions, wild jumps and samples at the top of the range
   function automatic logic [TW-1:0] next_tick_time();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         return sim_time_us;
      end
      if (roll < 60) begin
         sim_time_us += TW'($urandom_range(0, 2 * step_us));
      end else if (roll < 76) begin
         sim_time_us += TW'(step_us * $urandom_range(3, 14) + $urandom_range(0, step_us));
      end else if (roll < 83) begin
         sim_time_us -= TW'($urandom_range(0, 3 * step_us));
      end else if (roll < 92) begin
         sim_time_us = random_time();
      end else begin
         sim_time_us = TIME_MAX - TW'($urandom_range(0, 3 * step_us));
      end
      return sim_time_us;
   endfunction

   // One request transfer; entered and left at a falling edge
   task automatic send_item(input opcode_type op, input logic [TW-1:0] now);
      int gap;
      gap = idle_cycles();
      repeat (gap) @(negedge clock);
      req_chan.valid  = 1'b1;
      req_chan.opcode = op;
      req_chan.now_us = now;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   task automatic wait_drain();
      while (open_results != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Register write: setup cycle, then access cycle
   task automatic csr_write(input reg_index_type idx, input logic [15:0] value);
      logic [CSR_DATA_W-1:0] data;
      data = $urandom;
      if (idx == REG_RELOAD_TARGET) begin
         data[15:0] = value;
      end else begin
         data[0] = value[0];
      end
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Full register setup; the block is idle when this is called
   task automatic setup_timer(input logic [15:0] target, input logic fast,
                              input logic running, input logic handler);
      int unsigned eff;
      csr_write(REG_TIMER_RUNNING, 16'(running));
      csr_write(REG_HANDLER_INSTALLED, 16'(handler));
      csr_write(REG_RELOAD_TARGET, target);
      // period division runs after each target or divider write
      repeat (PERIOD_LOAD_CYCLES) @(negedge clock);
      csr_write(REG_CLOCK_SELECT, 16'(fast));
      repeat (PERIOD_LOAD_CYCLES) @(negedge clock);
      eff     = (target == '0) ? FULL_TARGET : target;
      step_us = eff * (fast ? 1 : SLOW_DIVIDER) / (CLOCK_HZ / US_PER_S) + 1;
   endtask

   // Mostly ticks, critical sections with deferred work inside, some noise
   task automatic run_traffic(input int count);
      int sent;
      int roll;
      int inner;
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(0, 99);
         if (roll < 62) begin
            send_item(OP_TICK, next_tick_time());
            sent++;
         end else if (roll < 72) begin
            send_item(OP_VBLANK, random_time());
            sent++;
         end else if (roll < 92) begin
            send_item(OP_ENTER, random_time());
            inner = $urandom_range(0, 4);
            repeat (inner) begin
               roll = $urandom_range(0, 99);
               if (roll < 55) begin
                  send_item(OP_TICK, next_tick_time());
               end else if (roll < 85) begin
                  send_item(OP_VBLANK, random_time());
               end else begin
                  send_item(OP_ENTER, random_time());
               end
            end
            send_item(OP_EXIT, random_time());
            sent += inner + 2;
         end else if (roll < 97) begin
            // stray exit outside a critical section
            send_item(OP_EXIT, random_time());
            sent++;
         end else begin
            wait_drain();
         end
      end
      wait_drain();
   endtask

   // Result side: random stall before each result transfer
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = idle_cycles();
         if (stall != 0) begin
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   initial begin
      req_chan.valid  = 1'b0;
      req_chan.opcode = OP_TICK;
      req_chan.now_us = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Registers at reset: timer idle, critical section still works
      send_item(OP_TICK, '0);
      send_item(OP_TICK, TIME_MAX);
      send_item(OP_ENTER, '0);
      send_item(OP_ENTER, TIME_MAX);
      send_item(OP_TICK, TW'(123));
      send_item(OP_VBLANK, '0);
      send_item(OP_EXIT, '0);
      send_item(OP_EXIT, TIME_MAX);
      send_item(OP_VBLANK, TIME_MAX);
      wait_drain();

      // Longest period: arm, exact deadline, catch-up with resync, saturation
      setup_timer(16'd0, 1'b0, 1'b1, 1'b1);
      send_item(OP_TICK, TW'(1000));
      send_item(OP_TICK, TW'(1000 + FULL_SLOW_PERIOD));
      send_item(OP_TICK, TW'(1000 + 21 * FULL_SLOW_PERIOD));
      send_item(OP_TICK, TIME_MAX - 1'b1);
      send_item(OP_TICK, TIME_MAX);
      send_item(OP_ENTER, '0);
      send_item(OP_TICK, TW'(5));
      send_item(OP_VBLANK, '0);
      send_item(OP_ENTER, '0);
      send_item(OP_EXIT, '0);
      send_item(OP_EXIT, '0);
      send_item(OP_TICK, '0);
      wait_drain();

      // Fixed settings, extremes among them
      setup_timer(16'd0, 1'b0, 1'b1, 1'b1);
      run_traffic(ITEMS_PER_PHASE);
      setup_timer(16'hFFFF, 1'b1, 1'b1, 1'b1);
      run_traffic(ITEMS_PER_PHASE);
      setup_timer(16'd34, 1'b1, 1'b1, 1'b1);
      run_traffic(ITEMS_PER_PHASE);
      setup_timer(16'd5, 1'b0, 1'b1, 1'b1);
      run_traffic(ITEMS_PER_PHASE);
      setup_timer(16'd1, 1'b1, 1'b1, 1'b1);
      run_traffic(ITEMS_PER_PHASE);
      setup_timer(16'd1000, 1'b0, 1'b0, 1'b1);
      run_traffic(ITEMS_PER_PHASE);
      setup_timer(16'd1000, 1'b0, 1'b1, 1'b0);
      run_traffic(ITEMS_PER_PHASE);
      setup_timer(16'd300, 1'b1, 1'b1, 1'b1);
      run_traffic(ITEMS_PER_PHASE);
      setup_timer(16'hFFFF, 1'b0, 1'b1, 1'b1);
      run_traffic(ITEMS_PER_PHASE);

      // Random settings
      repeat (RANDOM_SETUPS) begin
         case ($urandom_range(0, 3))
            0:       setup_timer(16'd0, 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0);
            1:       setup_timer(16'($urandom_range(1, 400)), 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0);
            default: setup_timer(16'($urandom), 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0);
         endcase
         run_traffic(ITEMS_PER_PHASE);
      end

      wait_drain();
      repeat (20) @(posedge clock);
      if (error_count == 0 && open_results == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
